[rtl/u2n_pkg.sv]
// Shared constants and types for the uniform-to-normal sample converter.
`timescale 1ns / 1ps
`default_nettype none

package u2n_pkg;

    // Fraction bits of the log2 mantissa term, one per squaring stage.
    localparam int LOG_FRAC_W = 32;

    // ln(2) in Q32.
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // -ln(1 - y^2) in Q32, capped at -ln(5e-16).
    localparam int NL_W = 38;
    localparam logic [NL_W-1:0] NL_FLOOR_Q32 = 38'd151319959532;

    // 2 / (pi * 0.147) in Q32.
    localparam int C_W = 35;
    localparam logic [C_W-1:0] C_Q32 = 35'd18600415663;

    // 1 / 0.147 in Q32, truncated.
    localparam int INV_A_W = 35;
    localparam logic [INV_A_W-1:0] INV_A_Q32 = 35'd29217464598;

    // |b| in Q32 and the Q64 radicand b^2 + (-l)/a.
    localparam int B_W     = 39;
    localparam int BABS_W  = 36;
    localparam int SUM_W   = 74;
    localparam int INNER_W = SUM_W / 2;
    localparam int R2_W    = INNER_W + 1;

    // Side data that travels with the radicand through the first root unit.
    typedef struct packed {
        logic              neg;
        logic              bneg;
        logic [BABS_W-1:0] babs;
    } t_root_side;

endpackage

`default_nettype wire

[rtl/u2n_logn.sv]
// Product u*(2^N-u), pipelined normalizer and squaring log2 pipeline.
`timescale 1ns / 1ps
`default_nettype none

module u2n_logn
    import u2n_pkg::*;
#(
    parameter int INPUT_BITS = 32,
    localparam int PW = 2 * INPUT_BITS,
    localparam int LZ_W = $clog2(PW)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [INPUT_BITS-1:0] i_uniform,
    output logic                       o_valid,
    output logic [LOG_FRAC_W-1:0]      o_frac,
    output logic [LZ_W-1:0]            o_lz,
    output logic                       o_neg,
    output logic                       o_zero
);

    localparam int H    = (INPUT_BITS + 1) / 2;
    localparam int HW   = INPUT_BITS - H;
    localparam int SQ_N = LOG_FRAC_W;

    // Stage 1: partial products of u squared, split into halves.
    logic [2*HW-1:0]       r_hh;
    logic [HW+H-1:0]       r_hl;
    logic [2*H-1:0]        r_ll;
    logic [INPUT_BITS-1:0] r_u;
    logic                  r_v1;
    logic                  r_neg1;
    logic                  r_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh   <= i_uniform[INPUT_BITS-1:H] * i_uniform[INPUT_BITS-1:H];
            r_hl   <= i_uniform[INPUT_BITS-1:H] * i_uniform[H-1:0];
            r_ll   <= i_uniform[H-1:0] * i_uniform[H-1:0];
            r_u    <= i_uniform;
            r_neg1 <= ~i_uniform[INPUT_BITS-1];
            r_z1   <= (i_uniform == '0);
        end
    end

    // Stage 2: p = u*2^N - u^2, exact in 2N bits.
    logic [PW-1:0] w_sq;
    logic [PW-1:0] w_p;

    assign w_sq = {r_hh, {(2*H){1'b0}}} + (PW'(r_hl) << (H + 1)) + PW'(r_ll);
    assign w_p  = {r_u, {INPUT_BITS{1'b0}}} - w_sq;

    logic [PW-1:0]   r_x   [0:LZ_W];
    logic [LZ_W-1:0] r_lz  [0:LZ_W];
    logic            r_nv  [0:LZ_W];
    logic            r_nneg[0:LZ_W];
    logic            r_nz  [0:LZ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv[0] <= 1'b0;
        end else if (i_en) begin
            r_nv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= w_p;
            r_lz[0]   <= '0;
            r_nneg[0] <= r_neg1;
            r_nz[0]   <= r_z1;
        end
    end

    // Normalizer: each stage tests one power-of-two run of leading zeros.
    for (genvar k = 0; k < LZ_W; k++) begin : g_norm
        localparam int SA = 1 << (LZ_W - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_nv[k+1] <= r_nv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_x[k][PW-1 -: SA] == '0) begin
                    r_x[k+1]  <= r_x[k] << SA;
                    r_lz[k+1] <= r_lz[k] + LZ_W'(SA);
                end else begin
                    r_x[k+1]  <= r_x[k];
                    r_lz[k+1] <= r_lz[k];
                end
                r_nneg[k+1] <= r_nneg[k];
                r_nz[k+1]   <= r_nz[k];
            end
        end
    end

    // Squaring pipeline: one fraction bit of log2(mantissa) per stage.
    logic [31:0]           w_m  [0:SQ_N];
    logic [LOG_FRAC_W-1:0] w_f  [0:SQ_N];
    logic [LZ_W-1:0]       w_lz [0:SQ_N];
    logic                  w_v  [0:SQ_N];
    logic                  w_neg[0:SQ_N];
    logic                  w_z  [0:SQ_N];

    assign w_m[0]   = r_x[LZ_W][PW-1 -: 32];
    assign w_f[0]   = '0;
    assign w_lz[0]  = r_lz[LZ_W];
    assign w_v[0]   = r_nv[LZ_W];
    assign w_neg[0] = r_nneg[LZ_W];
    assign w_z[0]   = r_nz[LZ_W];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sq
        logic [63:0]           w_sqr;
        logic [32:0]           w_t;
        logic [31:0]           r_m;
        logic [LOG_FRAC_W-1:0] r_f;
        logic [LZ_W-1:0]       r_l;
        logic                  r_v;
        logic                  r_n;
        logic                  r_z;

        assign w_sqr = 64'(w_m[j]) * 64'(w_m[j]);
        assign w_t   = w_sqr[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m <= w_t[32] ? w_t[32:1] : w_t[31:0];
                r_f <= {w_f[j][LOG_FRAC_W-2:0], w_t[32]};
                r_l <= w_lz[j];
                r_n <= w_neg[j];
                r_z <= w_z[j];
            end
        end

        assign w_m[j+1]   = r_m;
        assign w_f[j+1]   = r_f;
        assign w_lz[j+1]  = r_l;
        assign w_v[j+1]   = r_v;
        assign w_neg[j+1] = r_n;
        assign w_z[j+1]   = r_z;
    end

    assign o_valid = w_v[SQ_N];
    assign o_frac  = w_f[SQ_N];
    assign o_lz    = w_lz[SQ_N];
    assign o_neg   = w_neg[SQ_N];
    assign o_zero  = w_z[SQ_N];

    // The last mantissa is not needed past the final squaring stage.
    logic w_m_unused;
    assign w_m_unused = ^w_m[SQ_N];

endmodule

`default_nettype wire

[rtl/u2n_quad.sv]
// Forms -ln(1-y^2), b and the radicand b^2 + (-l)/a over six stages.
`timescale 1ns / 1ps
`default_nettype none

module u2n_quad
    import u2n_pkg::*;
#(
    parameter int LZ_W = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [LOG_FRAC_W-1:0] i_frac,
    input  wire logic [LZ_W-1:0]       i_lz,
    input  wire logic                  i_neg,
    input  wire logic                  i_zero,
    output logic                       o_valid,
    output logic [SUM_W-1:0]           o_sum,
    output t_root_side                 o_side
);

    localparam int KL_W  = LZ_W + 32;
    localparam int RAW_W = LZ_W + 33;

    // Valid bits of the six stages.
    logic [5:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Stage 1: integer and fraction parts of -log2 scaled by ln(2).
    logic [LZ_W-1:0] w_ip;
    logic [LZ_W-1:0] w_k;
    logic            w_fz;
    logic [32:0]     w_cf;
    logic [64:0]     w_fp;

    assign w_ip = i_lz - LZ_W'(1);
    assign w_fz = (i_frac == '0);
    assign w_k  = w_fz ? w_ip : ((w_ip == '0) ? '0 : w_ip - LZ_W'(1));
    assign w_cf = 33'h1_0000_0000 - {1'b0, i_frac};
    assign w_fp = w_cf * LN2_Q32;

    logic [KL_W-1:0] r_kl;
    logic [31:0]     r_fl;
    logic            r_small1;
    logic            r_z1;
    logic            r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kl     <= KL_W'(w_k) * KL_W'(LN2_Q32);
            r_fl     <= w_fz ? '0 : w_fp[63:32];
            r_small1 <= !w_fz && (w_ip == '0);
            r_z1     <= i_zero;
            r_neg1   <= i_neg;
        end
    end

    // Stage 2: sum and cap at the floor.
    logic [RAW_W-1:0] w_raw;
    logic [NL_W-1:0]  w_nl;

    assign w_raw = RAW_W'(r_kl) + RAW_W'(r_fl);

    always_comb begin
        if (r_z1) begin
            w_nl = NL_FLOOR_Q32;
        end else if (r_small1) begin
            w_nl = '0;
        end else if (w_raw > RAW_W'(NL_FLOOR_Q32)) begin
            w_nl = NL_FLOOR_Q32;
        end else begin
            w_nl = w_raw[NL_W-1:0];
        end
    end

    logic [NL_W-1:0] r_nl2;
    logic            r_neg2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nl2  <= w_nl;
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: b = C - nl/2 as sign and magnitude.
    logic [B_W-1:0] w_b;
    logic [B_W-1:0] w_bn;

    assign w_b  = B_W'(C_Q32) - B_W'(r_nl2[NL_W-1:1]);
    assign w_bn = '0 - w_b;

    logic [NL_W-1:0]   r_nl3;
    logic [BABS_W-1:0] r_babs3;
    logic              r_bneg3;
    logic              r_neg3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nl3   <= r_nl2;
            r_bneg3 <= w_b[B_W-1];
            r_babs3 <= w_b[B_W-1] ? w_bn[BABS_W-1:0] : w_b[BABS_W-1:0];
            r_neg3  <= r_neg2;
        end
    end

    // Stage 4: partial products of b^2 and nl/a.
    logic [17:0] w_bh;
    logic [17:0] w_bl;
    logic [18:0] w_nh;
    logic [18:0] w_nlo;
    logic [17:0] w_ih;
    logic [16:0] w_il;

    assign w_bh  = r_babs3[35:18];
    assign w_bl  = r_babs3[17:0];
    assign w_nh  = r_nl3[37:19];
    assign w_nlo = r_nl3[18:0];
    assign w_ih  = INV_A_Q32[34:17];
    assign w_il  = INV_A_Q32[16:0];

    logic [35:0] r_bhh;
    logic [35:0] r_bhl;
    logic [35:0] r_bll;
    logic [36:0] r_qhh;
    logic [35:0] r_qhl;
    logic [36:0] r_qlh;
    logic [35:0] r_qll;
    t_root_side  r_side4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bhh        <= w_bh * w_bh;
            r_bhl        <= w_bh * w_bl;
            r_bll        <= w_bl * w_bl;
            r_qhh        <= w_nh * w_ih;
            r_qhl        <= w_nh * w_il;
            r_qlh        <= w_nlo * w_ih;
            r_qll        <= w_nlo * w_il;
            r_side4.neg  <= r_neg3;
            r_side4.bneg <= r_bneg3;
            r_side4.babs <= r_babs3;
        end
    end

    // Stage 5: reduce each product to one word.
    logic [SUM_W-1:0] r_sb;
    logic [SUM_W-1:0] r_sq;
    t_root_side       r_side5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb <= (SUM_W'(r_bhh) << 36) + (SUM_W'(r_bhl) << 19) + SUM_W'(r_bll);
            r_sq <= (SUM_W'(r_qhh) << 36) + (SUM_W'(r_qhl) << 19)
                  + (SUM_W'(r_qlh) << 17) + SUM_W'(r_qll);
            r_side5 <= r_side4;
        end
    end

    // Stage 6: the radicand.
    logic [SUM_W-1:0] r_sum;
    t_root_side       r_side6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum   <= r_sb + r_sq;
            r_side6 <= r_side5;
        end
    end

    assign o_valid = r_v[5];
    assign o_sum   = r_sum;
    assign o_side  = r_side6;

endmodule

`default_nettype wire

[rtl/u2n_isqrt.sv]
// Pipelined restoring square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module u2n_isqrt #(
    parameter int IN_W = 74,
    parameter int SIDE_W = 1,
    localparam int RT_W = IN_W / 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [IN_W-1:0]   i_data,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [RT_W-1:0]        o_root,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int REM_W = RT_W + 2;

    logic [IN_W-1:0]   w_x   [0:RT_W-1];
    logic [REM_W-1:0]  w_rem [0:RT_W];
    logic [RT_W-1:0]   w_root[0:RT_W];
    logic [SIDE_W-1:0] w_side[0:RT_W];
    logic              w_v   [0:RT_W];

    assign w_x[0]    = i_data;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar j = 0; j < RT_W; j++) begin : g_stage
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;
        logic [REM_W-1:0]  r_rem;
        logic [RT_W-1:0]   r_root;
        logic [SIDE_W-1:0] r_side;
        logic              r_v;

        // Bring down two radicand bits and try the next root bit.
        assign w_cur   = {w_rem[j][REM_W-3:0], w_x[j][IN_W-1 -: 2]};
        assign w_trial = {w_root[j], 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_cur - w_trial : w_cur;
                r_root <= {w_root[j][RT_W-2:0], w_ge};
                r_side <= w_side[j];
            end
        end

        if (j < RT_W - 1) begin : g_x
            logic [IN_W-1:0] r_x;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x <= w_x[j] << 2;
                end
            end

            assign w_x[j+1] = r_x;
        end

        assign w_rem[j+1]  = r_rem;
        assign w_root[j+1] = r_root;
        assign w_side[j+1] = r_side;
        assign w_v[j+1]    = r_v;
    end

    assign o_valid = w_v[RT_W];
    assign o_root  = w_root[RT_W];
    assign o_side  = w_side[RT_W];

    // The final remainder is not needed.
    logic w_rem_unused;
    assign w_rem_unused = ^w_rem[RT_W];

endmodule

`default_nettype wire

[rtl/uniform_to_normal_sample.sv]
// Top level of the uniform-to-normal sample converter.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  input   | in        | i_valid / o_stall      | i_uniform (INPUT_BITS, unsigned)
//  output  | out       | o_valid / i_stall      | o_normal (Q4.F, signed), o_saturated
//
// One item enters per clock while o_stall is low. The log uses 32 squaring stages
// and both square roots produce one root bit per stage.
// Reset is synchronous and clears only valid bits.
// A stalled result waits in the output register; one more item lands in a skid
// register, and only then does the pipeline freeze and o_stall rise.
`timescale 1ns / 1ps
`default_nettype none

module uniform_to_normal_sample
    import u2n_pkg::*;
#(
    parameter int INPUT_BITS = 32,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [INPUT_BITS-1:0]     i_uniform,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [OUT_FRAC_BITS+3:0] o_normal,
    output logic                           o_saturated
);

    localparam int LZ_W   = $clog2(2 * INPUT_BITS);
    localparam int OUT_W  = 4 + OUT_FRAC_BITS;
    localparam int VSH    = 2 * OUT_FRAC_BITS - 32;
    localparam int VW     = R2_W + 1 + ((VSH > 0) ? VSH : 0);
    localparam int WW     = VW + 2 + ((VW + 2) % 2);
    localparam int RT2_W  = WW / 2;
    localparam int SIDE_W = $bits(t_root_side);

    logic w_en;

    // Log stage.
    logic                  w_lg_v;
    logic [LOG_FRAC_W-1:0] w_lg_frac;
    logic [LZ_W-1:0]       w_lg_lz;
    logic                  w_lg_neg;
    logic                  w_lg_z;

    u2n_logn #(
        .INPUT_BITS (INPUT_BITS)
    ) u_logn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_uniform (i_uniform),
        .o_valid   (w_lg_v),
        .o_frac    (w_lg_frac),
        .o_lz      (w_lg_lz),
        .o_neg     (w_lg_neg),
        .o_zero    (w_lg_z)
    );

    // Radicand stage.
    logic             w_qd_v;
    logic [SUM_W-1:0] w_qd_sum;
    t_root_side       w_qd_side;

    u2n_quad #(
        .LZ_W (LZ_W)
    ) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_lg_v),
        .i_frac  (w_lg_frac),
        .i_lz    (w_lg_lz),
        .i_neg   (w_lg_neg),
        .i_zero  (w_lg_z),
        .o_valid (w_qd_v),
        .o_sum   (w_qd_sum),
        .o_side  (w_qd_side)
    );

    // Inner square root.
    logic               w_s1_v;
    logic [INNER_W-1:0] w_inner;
    logic [SIDE_W-1:0]  w_s1_side;

    u2n_isqrt #(
        .IN_W   (SUM_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt_inner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qd_v),
        .i_data  (w_qd_sum),
        .i_side  (w_qd_side),
        .o_valid (w_s1_v),
        .o_root  (w_inner),
        .o_side  (w_s1_side)
    );

    // r2 = inner - b, scaled for the output fraction width.
    t_root_side      w_rs;
    logic [R2_W-1:0] w_r2;
    logic [VW-1:0]   w_vv;
    logic [WW-1:0]   w_w;

    assign w_rs = t_root_side'(w_s1_side);

    always_comb begin
        if (w_rs.bneg) begin
            w_r2 = R2_W'(w_inner) + R2_W'(w_rs.babs);
        end else if (w_inner >= INNER_W'(w_rs.babs)) begin
            w_r2 = R2_W'(w_inner) - R2_W'(w_rs.babs);
        end else begin
            w_r2 = '0;
        end
    end

    if (VSH >= 0) begin : g_up
        assign w_vv = VW'({w_r2, 1'b0}) << VSH;
    end else begin : g_down
        assign w_vv = VW'({w_r2, 1'b0} >> (-VSH));
    end

    assign w_w = WW'({w_vv, 2'b00});

    logic          r_r_v;
    logic [WW-1:0] r_w;
    logic          r_r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (w_en) begin
            r_r_v <= w_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w     <= w_w;
            r_r_neg <= w_rs.neg;
        end
    end

    // Outer square root, with one extra bit for rounding.
    logic             w_s2_v;
    logic [RT2_W-1:0] w_root2;
    logic             w_s2_neg;

    u2n_isqrt #(
        .IN_W   (WW),
        .SIDE_W (1)
    ) u_isqrt_outer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_r_v),
        .i_data  (r_w),
        .i_side  (r_r_neg),
        .o_valid (w_s2_v),
        .o_root  (w_root2),
        .o_side  (w_s2_neg)
    );

    // Round half up, apply the sign and saturate.
    logic [RT2_W:0]   w_rp1;
    logic [RT2_W-1:0] w_mag;
    logic [RT2_W-1:0] w_limit;
    logic [OUT_W-1:0] w_val;
    logic             w_sat;

    assign w_rp1   = {1'b0, w_root2} + (RT2_W + 1)'(1);
    assign w_mag   = w_rp1[RT2_W:1];
    assign w_limit = RT2_W'(1) << (OUT_FRAC_BITS + 3);

    always_comb begin
        if (w_s2_neg) begin
            w_sat = (w_mag > w_limit);
            w_val = w_sat ? {1'b1, {(OUT_W-1){1'b0}}} : ('0 - w_mag[OUT_W-1:0]);
        end else begin
            w_sat = (w_mag >= w_limit);
            w_val = w_sat ? {1'b0, {(OUT_W-1){1'b1}}} : w_mag[OUT_W-1:0];
        end
    end

    // Output register and skid register.
    logic             r_out_v;
    logic [OUT_W-1:0] r_out_val;
    logic             r_out_sat;
    logic             r_skid_v;
    logic [OUT_W-1:0] r_skid_val;
    logic             r_skid_sat;
    logic             n_out_v;
    logic             n_skid_v;
    logic             w_out_load;
    logic             w_skid_load;

    assign w_en = !r_skid_v;

    always_comb begin
        n_out_v     = r_out_v;
        n_skid_v    = r_skid_v;
        w_out_load  = 1'b0;
        w_skid_load = 1'b0;
        if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out_v    = w_s2_v;
                w_out_load = 1'b1;
            end
        end else if (w_s2_v && w_en) begin
            n_skid_v    = 1'b1;
            w_skid_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_val <= w_val;
            r_out_sat <= w_sat;
        end else if ((!r_out_v || !i_stall) && r_skid_v) begin
            r_out_val <= r_skid_val;
            r_out_sat <= r_skid_sat;
        end
        if (w_skid_load) begin
            r_skid_val <= w_val;
            r_skid_sat <= w_sat;
        end
    end

    assign o_stall     = r_skid_v;
    assign o_valid     = r_out_v;
    assign o_normal    = r_out_val;
    assign o_saturated = r_out_sat;

endmodule

`default_nettype wire

[dv/uniform_to_normal_sample_test.sv]
// Self-checking testbench for the uniform-to-normal sample converter.
`timescale 1ns / 1ps
`default_nettype none

module uniform_to_normal_sample_test;
    import u2n_pkg::*;

    localparam int UW = 32;
    localparam int FW = 16;
    localparam int OW = FW + 4;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_LIMIT = 3000;

    // One uniform sample, with a hand-typed expectation where it is obvious.
    typedef struct {
        logic [UW-1:0] uniform;
        bit            typed;
        logic [OW-1:0] normal;
        logic          saturated;
    } t_sample_row;

    typedef struct {
        logic [OW-1:0] normal;
        logic          saturated;
    } t_normal_item;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [UW-1:0] i_uniform = '0;
    logic          i_stall = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic signed [OW-1:0] o_normal;
    logic          o_saturated;

    t_sample_row   sample_rows[$];
    t_normal_item  pending_normals[$];
    int            sent_count = 0;
    int            recv_count = 0;
    int            error_count = 0;
    int            idle_cycles = 0;

    uniform_to_normal_sample #(
        .INPUT_BITS(UW),
        .OUT_FRAC_BITS(FW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_uniform(i_uniform),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_normal(o_normal),
        .o_saturated(o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // Floor of the square root of a 128-bit value, one bit per step.
    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    // -ln(1 - y^2) in Q32 from the exact product u * (2^N - u).
    function automatic logic [63:0] neg_ln_q32(input logic [63:0] u);
        logic [127:0] p;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [63:0]  nl;
        int           e;
        int           ip;
        p = {64'd0, u} * ({64'd0, 64'd1 << UW} - {64'd0, u});
        if (p == 0) begin
            return 64'(NL_FLOOR_Q32);
        end
        e = 0;
        for (int i = 0; i < 128; i++) begin
            if (p[i]) begin
                e = i;
            end
        end
        if (e >= 31) begin
            m = 64'(p >> (e - 31));
        end else begin
            m = 64'(p) << (31 - e);
        end
        m = m & 64'hFFFF_FFFF;
        frac = '0;
        // Fraction bits of log2 of the mantissa by repeated squaring.
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        ip = 2 * UW - 2 - e;
        if (frac == 0) begin
            nl = 64'((ip < 0) ? 0 : ip) * 64'(LN2_Q32);
        end else if (ip < 1) begin
            nl = '0;
        end else begin
            nl = 64'(ip - 1) * 64'(LN2_Q32)
                + ((((64'd1 << 32) - frac) * 64'(LN2_Q32)) >> 32);
        end
        return (nl > 64'(NL_FLOOR_Q32)) ? 64'(NL_FLOOR_Q32) : nl;
    endfunction

    // Normal sample for one uniform fraction, Winitzki erfinv in fixed point.
    function automatic t_normal_item gaussian_of(input logic [UW-1:0] uniform);
        t_normal_item       res;
        logic [63:0]        nl;
        logic signed [63:0] b;
        logic [63:0]        babs;
        logic [127:0]       radicand;
        logic [63:0]        inner;
        logic [63:0]        r2;
        logic [63:0]        v;
        logic [63:0]        mag;
        logic [63:0]        limit;
        nl = neg_ln_q32({32'd0, uniform});
        b = $signed(64'(C_Q32)) - $signed(nl >> 1);
        babs = (b < 0) ? 64'(-b) : 64'(b);
        radicand = {64'd0, babs} * {64'd0, babs} + {64'd0, nl} * {64'd0, 64'(INV_A_Q32)};
        inner = floor_root(radicand);
        if (b < 0) begin
            r2 = inner + babs;
        end else begin
            r2 = (inner >= babs) ? inner - babs : 64'd0;
        end
        v = r2 << 1;
        if (2 * FW - 32 >= 0) begin
            v = v << (2 * FW - 32);
        end else begin
            v = v >> (32 - 2 * FW);
        end
        mag = (floor_root({64'd0, v << 2}) + 64'd1) >> 1;
        limit = 64'd8 << FW;
        res.saturated = 1'b0;
        if (uniform < (33'd1 << (UW - 1))) begin
            if (mag > limit) begin
                mag = limit;
                res.saturated = 1'b1;
            end
            res.normal = OW'(64'd0 - mag);
        end else begin
            if (mag > limit - 1) begin
                mag = limit - 1;
                res.saturated = 1'b1;
            end
            res.normal = OW'(mag);
        end
        return res;
    endfunction

    function automatic t_sample_row plain_row(input logic [UW-1:0] u);
        t_sample_row row;
        row.uniform = u;
        row.typed = 1'b0;
        row.normal = '0;
        row.saturated = 1'b0;
        return row;
    endfunction

    // Stimulus: directed table first, then a random mix biased to the tails.
    initial begin
        t_sample_row row;
        logic [UW-1:0] u;
        row = plain_row('0);
        row.typed = 1'b1;
        row.normal = OW'(-(8 << FW));
        row.saturated = 1'b1;
        sample_rows.push_back(row);
        row = plain_row(32'h8000_0000);
        row.typed = 1'b1;
        sample_rows.push_back(row);
        sample_rows.push_back(plain_row(32'h0000_0001));
        sample_rows.push_back(plain_row(32'h0000_0002));
        sample_rows.push_back(plain_row(32'h0000_0100));
        sample_rows.push_back(plain_row(32'h0001_0000));
        sample_rows.push_back(plain_row(32'h7FFF_FFFF));
        sample_rows.push_back(plain_row(32'h8000_0001));
        sample_rows.push_back(plain_row(32'hFFFF_FFFF));
        sample_rows.push_back(plain_row(32'hFFFF_FFFE));
        sample_rows.push_back(plain_row(32'hFFFF_0000));
        sample_rows.push_back(plain_row(32'h5555_5555));
        sample_rows.push_back(plain_row(32'hAAAA_AAAA));
        sample_rows.push_back(plain_row(32'h4000_0000));
        sample_rows.push_back(plain_row(32'hC000_0000));
        sample_rows.push_back(plain_row(32'h0F0F_0F0F));
        sample_rows.push_back(plain_row(32'hF0F0_F0F0));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(7))
                0, 1, 2, 3: u = $urandom;
                4: u = $urandom >> $urandom_range(31);
                5: u = ~($urandom >> $urandom_range(31));
                6: u = 32'h8000_0000 + ($urandom >> $urandom_range(31, 8))
                       - ($urandom >> $urandom_range(31, 8));
                default: u = 32'd1 << $urandom_range(31);
            endcase
            sample_rows.push_back(plain_row(u));
        end
    end

    // Reset at the start of the run, once.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Sender: hold each item until accepted, idle at random outside a quiet window.
    always @(posedge i_clk) begin
        logic          next_valid;
        logic [UW-1:0] next_uniform;
        bit            quiet;
        next_valid = i_valid;
        next_uniform = i_uniform;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (sample_rows[sent_count].typed) begin
                    pending_normals.push_back('{sample_rows[sent_count].normal,
                                                sample_rows[sent_count].saturated});
                end else begin
                    pending_normals.push_back(gaussian_of(sample_rows[sent_count].uniform));
                end
                sent_count = sent_count + 1;
                next_valid = 1'b0;
            end
            quiet = (sent_count >= 150 && sent_count < 300);
            if (!next_valid && sent_count < sample_rows.size()) begin
                if (quiet || $urandom_range(99) >= 26) begin
                    next_valid = 1'b1;
                    next_uniform = sample_rows[sent_count].uniform;
                end
            end
        end
        i_valid <= next_valid;
        i_uniform <= next_uniform;
    end

    // Receiver: check each accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_normal_item want;
        bit           quiet;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_normals.size() == 0) begin
                    $display("%0t: unexpected item normal=%h saturated=%b",
                             $time, o_normal, o_saturated);
                    error_count = error_count + 1;
                end else begin
                    want = pending_normals.pop_front();
                    if (o_normal !== want.normal) begin
                        $display("%0t: normal expected %h actual %h", $time,
                                 want.normal, o_normal);
                        error_count = error_count + 1;
                    end
                    if (o_saturated !== want.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, o_saturated);
                        error_count = error_count + 1;
                    end
                end
                recv_count = recv_count + 1;
            end
        end
        quiet = (recv_count >= 100 && recv_count < 250);
        i_stall <= !quiet && ($urandom_range(99) < 26);
    end

    // Watchdog on cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // End of run: drain, let stragglers surface, then report.
    initial begin
        wait (i_rst_n);
        wait (sample_rows.size() > 0 && sent_count == sample_rows.size());
        wait (pending_normals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_normals.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
